FILE: sv/nrf_pkg.sv
// Shared types, constants and helpers for the neighbor reachability block.
package nrf_pkg;

    localparam int TS_W           = 32;
    localparam int CNT_W          = 8;
    localparam int ADDR_W         = 48;
    localparam int CFG_W          = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int Q_DEPTH        = 2;

    localparam int HOLD_LIMIT_DEF      = 255;
    localparam int LINK_ADDR_BYTES_DEF = 6;

    localparam logic [TS_W-1:0]  REACHABLE_RST   = 32'd30000;
    localparam logic [TS_W-1:0]  RETRANSMIT_RST  = 32'd1000;
    localparam logic [TS_W-1:0]  PROBE_DELAY_RST = 32'd5000;
    localparam logic [CNT_W-1:0] MAX_RETX_RST    = 8'd3;
    localparam logic [TS_W-1:0]  FIRST_RES_RST   = 32'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REACHABLE   = 3'd0,
        CFG_RETRANSMIT  = 3'd1,
        CFG_PROBE_DELAY = 3'd2,
        CFG_MAX_RETX    = 3'd3,
        CFG_FIRST_RES   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_PACKET  = 2'd1,
        CMD_CONFIRM = 2'd2,
        CMD_REMOVE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_INCOMPLETE = 3'd1,
        ST_REACHABLE  = 3'd2,
        ST_STALE      = 3'd3,
        ST_DELAY      = 3'd4,
        ST_PROBE      = 3'd5,
        ST_FAILED     = 3'd6
    } t_nud;

    // One classified request as it sits in the queue.
    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] addr;
    } t_req;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic              send_now;
        logic              held;
        logic              dropped;
        logic              solicit;
        logic [CNT_W-1:0]  flush_count;
        t_nud              entry_state;
        logic [ADDR_W-1:0] hw_address;
    } t_result;

    // Wrap-safe a <= b on timestamps.
    function automatic logic time_reached(input logic [TS_W-1:0] a,
                                          input logic [TS_W-1:0] b);
        logic [TS_W-1:0] diff;
        diff = b - a;
        return ~diff[TS_W-1];
    endfunction

endpackage

FILE: sv/nrf_front.sv
// Front end: takes requests, decodes the command and trims the link address.
module nrf_front import nrf_pkg::*; #(
    parameter int LINK_ADDR_BYTES = LINK_ADDR_BYTES_DEF
) (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_command,
    input  logic [ADDR_W-1:0] i_link_address,
    input  t_qstat            i_qstat,
    output logic              o_push,
    output t_req              o_req
);

    localparam int ADDR_KEEP = (LINK_ADDR_BYTES >= 6) ? ADDR_W : 8 * LINK_ADDR_BYTES;
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_KEEP);

    t_cmd cmd;

    always_comb begin
        unique case (i_command)
            2'd0:    cmd = CMD_TICK;
            2'd1:    cmd = CMD_PACKET;
            2'd2:    cmd = CMD_CONFIRM;
            default: cmd = CMD_REMOVE;
        endcase
    end

    assign o_ready   = ~i_qstat.full;
    assign o_push    = i_valid & ~i_qstat.full;
    assign o_req.cmd = cmd;
    // address only matters for a confirmation
    assign o_req.addr = (cmd == CMD_CONFIRM) ? (i_link_address & ADDR_MASK) : '0;

endmodule

FILE: sv/nrf_queue.sv
// Short request queue between the front end and the state engine.
module nrf_queue import nrf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_req   i_req,
    input  logic   i_pop,
    output t_req   o_head,
    output t_qstat o_qstat
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW    = $clog2(Q_DEPTH + 1);

    t_req             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    assign o_head        = r_mem[r_rd_ptr];
    assign o_qstat.full  = (r_count == CW'(Q_DEPTH));
    assign o_qstat.empty = (r_count == '0);

endmodule

FILE: sv/nrf_back.sv
// State engine: entry state, timers, hold count and the result register.
module nrf_back import nrf_pkg::*; #(
    parameter int HOLD_LIMIT = HOLD_LIMIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_qstat               i_qstat,
    input  t_req                 i_req,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_result              o_result
);

    // configuration
    logic [TS_W-1:0]  r_reach, r_retx, r_probe_delay, r_first_res;
    logic [CNT_W-1:0] r_max_retx;

    // entry state
    t_nud              r_state, n_state;
    logic [TS_W-1:0]   r_tick, n_tick;
    logic [TS_W-1:0]   r_deadline, n_deadline;
    logic              r_armed, n_armed;
    logic [TS_W-1:0]   r_confirmed, n_confirmed;
    logic [TS_W-1:0]   r_delay_at, n_delay_at;
    logic [CNT_W-1:0]  r_retry, n_retry;
    logic [CNT_W-1:0]  r_held, n_held;
    logic [ADDR_W-1:0] r_addr, n_addr;

    logic            r_out_valid;
    t_result         r_out, res;
    logic [TS_W-1:0] tick_next, fresh_until, probe_due;

    assign o_pop = ~i_qstat.empty & (~r_out_valid | i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reach       <= REACHABLE_RST;
            r_retx        <= RETRANSMIT_RST;
            r_probe_delay <= PROBE_DELAY_RST;
            r_max_retx    <= MAX_RETX_RST;
            r_first_res   <= FIRST_RES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REACHABLE:   r_reach       <= i_cfg_data;
                CFG_RETRANSMIT:  r_retx        <= i_cfg_data;
                CFG_PROBE_DELAY: r_probe_delay <= i_cfg_data;
                CFG_MAX_RETX:    r_max_retx    <= i_cfg_data[CNT_W-1:0];
                CFG_FIRST_RES:   r_first_res   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_deadline  = r_deadline;
        n_armed     = r_armed;
        n_confirmed = r_confirmed;
        n_delay_at  = r_delay_at;
        n_retry     = r_retry;
        n_held      = r_held;
        n_addr      = r_addr;
        res         = '0;
        tick_next   = r_tick + TS_W'(1);
        fresh_until = r_confirmed + r_reach;
        probe_due   = r_delay_at + r_probe_delay;

        unique case (i_req.cmd)
            CMD_TICK: begin
                n_tick = tick_next;
                if (r_armed && time_reached(r_deadline, tick_next)) begin
                    n_armed = 1'b0;
                    unique case (r_state) inside
                        ST_INCOMPLETE, ST_PROBE: begin
                            if (r_retry != '1) begin
                                n_retry = r_retry + CNT_W'(1);
                            end
                            if (r_retry > r_max_retx) begin
                                n_state = ST_FAILED;
                            end else begin
                                n_deadline  = tick_next + r_retx;
                                n_armed     = 1'b1;
                                res.solicit = 1'b1;
                            end
                        end
                        ST_REACHABLE: begin
                            if (time_reached(fresh_until, tick_next)) begin
                                n_state = ST_STALE;
                            end else begin
                                n_deadline = fresh_until;
                                n_armed    = 1'b1;
                            end
                        end
                        ST_DELAY: begin
                            if (time_reached(probe_due, tick_next)) begin
                                n_state     = ST_PROBE;
                                n_retry     = '0;
                                n_deadline  = tick_next + r_retx;
                                n_armed     = 1'b1;
                                res.solicit = 1'b1;
                            end else if (!time_reached(fresh_until, tick_next)) begin
                                n_state    = ST_REACHABLE;
                                n_deadline = fresh_until;
                                n_armed    = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_PACKET: begin
                unique case (r_state) inside
                    ST_REACHABLE, ST_DELAY: begin
                        res.send_now = 1'b1;
                    end
                    ST_STALE: begin
                        n_state      = ST_DELAY;
                        n_delay_at   = r_tick;
                        n_deadline   = r_tick + r_probe_delay;
                        n_armed      = 1'b1;
                        res.send_now = 1'b1;
                    end
                    default: begin
                        if (r_held < CNT_W'(HOLD_LIMIT)) begin
                            n_held   = r_held + CNT_W'(1);
                            res.held = 1'b1;
                        end else begin
                            res.dropped = 1'b1;
                        end
                        if (r_state != ST_PROBE && r_state != ST_INCOMPLETE) begin
                            n_retry     = '0;
                            n_state     = ST_INCOMPLETE;
                            n_deadline  = r_tick + r_first_res;
                            n_armed     = 1'b1;
                            res.solicit = 1'b1;
                        end
                    end
                endcase
            end
            CMD_CONFIRM: begin
                n_addr          = i_req.addr;
                n_state         = ST_REACHABLE;
                n_confirmed     = r_tick;
                n_deadline      = r_tick + r_reach;
                n_armed         = 1'b1;
                res.flush_count = r_held;
                n_held          = '0;
            end
            default: begin
                n_state     = ST_NONE;
                n_deadline  = '0;
                n_armed     = 1'b0;
                n_confirmed = '0;
                n_delay_at  = '0;
                n_retry     = '0;
                n_held      = '0;
                n_addr      = '0;
            end
        endcase

        res.entry_state = n_state;
        res.hw_address  = n_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_NONE;
            r_tick      <= '0;
            r_deadline  <= '0;
            r_armed     <= 1'b0;
            r_confirmed <= '0;
            r_delay_at  <= '0;
            r_retry     <= '0;
            r_held      <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state     <= n_state;
                r_tick      <= n_tick;
                r_deadline  <= n_deadline;
                r_armed     <= n_armed;
                r_confirmed <= n_confirmed;
                r_delay_at  <= n_delay_at;
                r_retry     <= n_retry;
                r_held      <= n_held;
                r_addr      <= n_addr;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: sv/neighbour_reachability_fsm.sv
// Top level: neighbor reachability engine for one ARP/NDP entry.
// A taken request is queued, and the state engine settles it into the result register.
// Throughput: one request per cycle while the result register is free or being read.
// The two-entry request queue and the result register decouple input and output stalls.
// Reset (synchronous, active low) clears the entry, tick clock and queue and loads
// the default timer settings; requests are taken from the first cycle after reset.
module neighbour_reachability_fsm import nrf_pkg::*; #(
    parameter int HOLD_LIMIT      = HOLD_LIMIT_DEF,
    parameter int LINK_ADDR_BYTES = LINK_ADDR_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_command,
    input  logic [ADDR_W-1:0]    i_link_address,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_send_now,
    output logic                 o_held,
    output logic                 o_dropped,
    output logic                 o_solicit,
    output logic [CNT_W-1:0]     o_flush_count,
    output logic [2:0]           o_entry_state,
    output logic [ADDR_W-1:0]    o_hw_address
);

    t_qstat  qstat;
    t_req    push_req, head_req;
    logic    push, pop;
    t_result result;

    // Front: decode the command, keep only the used address bytes.
    nrf_front #(
        .LINK_ADDR_BYTES(LINK_ADDR_BYTES)
    ) u_front (
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_command      (i_command),
        .i_link_address (i_link_address),
        .i_qstat        (qstat),
        .o_push         (push),
        .o_req          (push_req)
    );

    // Queue between front and state engine.
    nrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (push_req),
        .i_pop   (pop),
        .o_head  (head_req),
        .o_qstat (qstat)
    );

    // State engine; pops one request per cycle while the result register is free.
    nrf_back #(
        .HOLD_LIMIT(HOLD_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_qstat     (qstat),
        .i_req       (head_req),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_result    (result)
    );

    assign o_send_now    = result.send_now;
    assign o_held        = result.held;
    assign o_dropped     = result.dropped;
    assign o_solicit     = result.solicit;
    assign o_flush_count = result.flush_count;
    assign o_entry_state = result.entry_state;
    assign o_hw_address  = result.hw_address;

    // A packet is either sent, held or dropped, never two at once.
    a_packet_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_send_now && (o_held || o_dropped)) && !(o_held && o_dropped))
        else $error("packet outcome flags overlap");

    // A flush only comes with a confirmation, which leaves the entry reachable.
    a_flush_reachable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_flush_count != '0) |-> o_entry_state == 3'(ST_REACHABLE))
        else $error("flush without reachable state");

    // Solicitations are only sent while resolving or probing.
    a_solicit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_solicit) |->
            (o_entry_state == 3'(ST_INCOMPLETE) || o_entry_state == 3'(ST_PROBE)))
        else $error("solicit outside incomplete/probe");

    // The queue is never popped while empty nor written while full.
    a_queue_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && qstat.empty) && !(push && qstat.full))
        else $error("queue overrun or underrun");

endmodule

FILE: tb/nrf_result_checker.sv
// Response checker for the neighbor reachability block: predicts and compares every response.
`timescale 1ns / 1ps
module nrf_result_checker import nrf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [1:0]           i_command,
    input  logic [ADDR_W-1:0]    i_link_address,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_send_now,
    input  logic                 i_held,
    input  logic                 i_dropped,
    input  logic                 i_solicit,
    input  logic [CNT_W-1:0]     i_flush_count,
    input  logic [2:0]           i_entry_state,
    input  logic [ADDR_W-1:0]    i_hw_address,
    output int                   o_outstanding,
    output int                   o_mismatches,
    output int                   o_responses
);

    localparam logic [ADDR_W-1:0] ADDR_KEEP = (LINK_ADDR_BYTES_DEF >= 6) ? {ADDR_W{1'b1}} :
        ((48'd1 << (8 * LINK_ADDR_BYTES_DEF)) - 48'd1);

    // timer settings
    logic [TS_W-1:0]   reach_ticks;
    logic [TS_W-1:0]   retx_ticks;
    logic [TS_W-1:0]   probe_delay_ticks;
    logic [TS_W-1:0]   resolve_ticks;
    logic [CNT_W-1:0]  retx_limit;

    // predicted entry
    t_nud              nud;
    logic [TS_W-1:0]   clock_ticks;
    logic [TS_W-1:0]   timer_due;
    logic              timer_on;
    logic [TS_W-1:0]   confirmed_tick;
    logic [TS_W-1:0]   delay_tick;
    logic [CNT_W-1:0]  retries;
    logic [CNT_W-1:0]  held_pkts;
    logic [ADDR_W-1:0] link_addr;

    t_result           awaited [$];
    t_result           want;
    t_result           got;
    bit                field_bad;
    int                errors    = 0;
    int                responses = 0;

    // when <= now, wrap-safe
    function automatic logic reached(input logic [TS_W-1:0] when, input logic [TS_W-1:0] now);
        logic [TS_W-1:0] lag;
        lag = now - when;
        return !lag[TS_W-1];
    endfunction

    task automatic arm(input logic [TS_W-1:0] when);
        timer_due = when;
        timer_on  = 1'b1;
    endtask

    task automatic forget_neighbor();
        nud            = ST_NONE;
        timer_due      = '0;
        timer_on       = 1'b0;
        confirmed_tick = '0;
        delay_tick     = '0;
        retries        = '0;
        held_pkts      = '0;
        link_addr      = '0;
    endtask

    task automatic step_entry(input t_cmd cmd, input logic [ADDR_W-1:0] addr,
                              output t_result r);
        logic [TS_W-1:0] fresh_until;
        logic            over;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                clock_ticks = clock_ticks + TS_W'(1);
                fresh_until = confirmed_tick + reach_ticks;
                if (timer_on && reached(timer_due, clock_ticks)) begin
                    timer_on = 1'b0;
                    case (nud)
                        ST_INCOMPLETE, ST_PROBE: begin
                            over = retries > retx_limit;
                            if (retries != '1)
                                retries = retries + CNT_W'(1);
                            if (over) begin
                                nud = ST_FAILED;
                            end else begin
                                arm(clock_ticks + retx_ticks);
                                r.solicit = 1'b1;
                            end
                        end
                        ST_REACHABLE: begin
                            if (reached(fresh_until, clock_ticks))
                                nud = ST_STALE;
                            else
                                arm(fresh_until);
                        end
                        ST_DELAY: begin
                            if (reached(delay_tick + probe_delay_ticks, clock_ticks)) begin
                                nud     = ST_PROBE;
                                retries = '0;
                                arm(clock_ticks + retx_ticks);
                                r.solicit = 1'b1;
                            end else if (!reached(fresh_until, clock_ticks)) begin
                                nud = ST_REACHABLE;
                                arm(fresh_until);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            CMD_PACKET: begin
                if (nud == ST_REACHABLE || nud == ST_DELAY) begin
                    r.send_now = 1'b1;
                end else if (nud == ST_STALE) begin
                    nud        = ST_DELAY;
                    delay_tick = clock_ticks;
                    arm(clock_ticks + probe_delay_ticks);
                    r.send_now = 1'b1;
                end else begin
                    if (held_pkts < HOLD_LIMIT_DEF) begin
                        held_pkts = held_pkts + CNT_W'(1);
                        r.held    = 1'b1;
                    end else begin
                        r.dropped = 1'b1;
                    end
                    if (nud != ST_PROBE && nud != ST_INCOMPLETE) begin
                        retries = '0;
                        nud     = ST_INCOMPLETE;
                        arm(clock_ticks + resolve_ticks);
                        r.solicit = 1'b1;
                    end
                end
            end
            CMD_CONFIRM: begin
                link_addr      = addr & ADDR_KEEP;
                nud            = ST_REACHABLE;
                confirmed_tick = clock_ticks;
                arm(clock_ticks + reach_ticks);
                r.flush_count  = held_pkts;
                held_pkts      = '0;
            end
            default: forget_neighbor();
        endcase
        r.entry_state = nud;
        r.hw_address  = link_addr;
    endtask

    task automatic compare_field(input string name, input logic [ADDR_W-1:0] exp_val,
                                 input logic [ADDR_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, exp_val, act_val);
            field_bad = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reach_ticks       = REACHABLE_RST;
            retx_ticks        = RETRANSMIT_RST;
            probe_delay_ticks = PROBE_DELAY_RST;
            retx_limit        = MAX_RETX_RST;
            resolve_ticks     = FIRST_RES_RST;
            clock_ticks       = '0;
            forget_neighbor();
            awaited.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REACHABLE:   reach_ticks       = i_cfg_data;
                    CFG_RETRANSMIT:  retx_ticks        = i_cfg_data;
                    CFG_PROBE_DELAY: probe_delay_ticks = i_cfg_data;
                    CFG_MAX_RETX:    retx_limit        = i_cfg_data[CNT_W-1:0];
                    CFG_FIRST_RES:   resolve_ticks     = i_cfg_data;
                    default: ;
                endcase
            end
            // each response comes through the queue and result register, so pop before push
            if (i_out_valid && i_out_ready) begin
                got.send_now    = i_send_now;
                got.held        = i_held;
                got.dropped     = i_dropped;
                got.solicit     = i_solicit;
                got.flush_count = i_flush_count;
                got.entry_state = t_nud'(i_entry_state);
                got.hw_address  = i_hw_address;
                responses++;
                if (awaited.size() == 0) begin
                    errors++;
                    $display("%0t ns: expected no response, got state %0d address %0h",
                             $time, i_entry_state, i_hw_address);
                end else begin
                    want      = awaited.pop_front();
                    field_bad = 1'b0;
                    compare_field("send_now", ADDR_W'(want.send_now), ADDR_W'(got.send_now));
                    compare_field("held", ADDR_W'(want.held), ADDR_W'(got.held));
                    compare_field("dropped", ADDR_W'(want.dropped), ADDR_W'(got.dropped));
                    compare_field("solicit", ADDR_W'(want.solicit), ADDR_W'(got.solicit));
                    compare_field("flush_count", ADDR_W'(want.flush_count),
                                  ADDR_W'(got.flush_count));
                    compare_field("entry_state", ADDR_W'(want.entry_state),
                                  ADDR_W'(got.entry_state));
                    compare_field("hw_address", want.hw_address, got.hw_address);
                    if (field_bad)
                        errors++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                step_entry(t_cmd'(i_command), i_link_address, want);
                awaited.push_back(want);
            end
        end
        o_outstanding <= awaited.size();
        o_mismatches  <= errors;
        o_responses   <= responses;
    end

endmodule

FILE: tb/neighbour_reachability_fsm_test.sv
// Testbench top for the neighbor reachability block: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module neighbour_reachability_fsm_test;
    import nrf_pkg::*;

    // Index past the last register: writes there must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    // Idle cycles before a settings change and at the very end; covers the
    // request queue and result register.
    localparam int SETTLE_CYCLES = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_command;
    logic [ADDR_W-1:0]    i_link_address;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_send_now;
    logic                 o_held;
    logic                 o_dropped;
    logic                 o_solicit;
    logic [CNT_W-1:0]     o_flush_count;
    logic [2:0]           o_entry_state;
    logic [ADDR_W-1:0]    o_hw_address;

    int n_outstanding;
    int n_mismatches;
    int n_responses;

    // request counters for the run summary
    int n_sent     = 0;
    int n_ticks    = 0;
    int n_packets  = 0;
    int n_confirms = 0;
    int n_removes  = 0;
    int n_settings = 0;

    // "calm" stretches: no idling on that side until the flag flips again
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    // settings currently loaded; used only to size tick runs
    logic [TS_W-1:0] cur_reach;
    logic [TS_W-1:0] cur_retx;
    logic [TS_W-1:0] cur_pdelay;

    neighbour_reachability_fsm u_top (.*);

    nrf_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_link_address (i_link_address),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_send_now     (o_send_now),
        .i_held         (o_held),
        .i_dropped      (o_dropped),
        .i_solicit      (o_solicit),
        .i_flush_count  (o_flush_count),
        .i_entry_state  (o_entry_state),
        .i_hw_address   (o_hw_address),
        .o_outstanding  (n_outstanding),
        .o_mismatches   (n_mismatches),
        .o_responses    (n_responses)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard stop in case a handshake never completes or a response goes missing.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Mostly random link addresses, with all-zero and all-one corners mixed in.
    function automatic logic [ADDR_W-1:0] any_addr();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return raw[ADDR_W-1:0];
        endcase
    endfunction

    // Ticks dominate so that timers actually run out.
    function automatic t_cmd any_cmd();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 10)
            return CMD_TICK;
        else if (pick < 15)
            return CMD_PACKET;
        else if (pick < 18)
            return CMD_CONFIRM;
        return CMD_REMOVE;
    endfunction

    // Tick run long enough to cross an interval, capped for huge settings.
    function automatic int span(input logic [TS_W-1:0] ticks);
        return (ticks > 10) ? 12 : int'(ticks) + 2;
    endfunction

    // One request on the input channel. Called at a falling edge and returns
    // at the falling edge after the request is taken. Valid only drops when
    // a gap is drawn, so back-to-back requests keep it high.
    task automatic send_req(input t_cmd cmd, input logic [ADDR_W-1:0] addr);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_link_address <= addr;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
        case (cmd)
            CMD_TICK:    n_ticks++;
            CMD_PACKET:  n_packets++;
            CMD_CONFIRM: n_confirms++;
            default:     n_removes++;
        endcase
    endtask

    // The address on a tick is ignored by the block; randomize it anyway.
    task automatic send_ticks(input int count);
        repeat (count)
            send_req(CMD_TICK, any_addr());
    endtask

    // Stop sending and wait until every response is back and the pipe is quiet.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (n_outstanding != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES)
            @(negedge i_clk);
    endtask

    // Load all five timer settings on back-to-back cycles, then poke the
    // unused index. The entry state is kept across the change on purpose.
    task automatic load_settings(input logic [TS_W-1:0] reach, input logic [TS_W-1:0] retx,
                                 input logic [TS_W-1:0] pdelay, input logic [CNT_W-1:0] limit,
                                 input logic [TS_W-1:0] resolve);
        logic [CFG_W-1:0] limit_word;
        quiesce();
        // upper bits of the retry limit word are junk the block must ignore
        limit_word = ($urandom & 32'hFFFF_FF00) | CFG_W'(limit);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_REACHABLE;
        i_cfg_data  <= reach;
        @(negedge i_clk);
        i_cfg_index <= CFG_RETRANSMIT;
        i_cfg_data  <= retx;
        @(negedge i_clk);
        i_cfg_index <= CFG_PROBE_DELAY;
        i_cfg_data  <= pdelay;
        @(negedge i_clk);
        i_cfg_index <= CFG_MAX_RETX;
        i_cfg_data  <= limit_word;
        @(negedge i_clk);
        i_cfg_index <= CFG_FIRST_RES;
        i_cfg_data  <= resolve;
        @(negedge i_clk);
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= $urandom;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_reach  = reach;
        cur_retx   = retx;
        cur_pdelay = pdelay;
        n_settings++;
    endtask

    // Typical life of an entry: resolve, confirm, age to stale, send (delay),
    // run into probe, then confirm, remove or neither. Lengths and addresses are random.
    task automatic lifecycle();
        send_req(CMD_PACKET, any_addr());
        send_ticks($urandom_range(0, 3 * span(cur_retx)));
        if ($urandom_range(0, 3) != 0)
            send_req(CMD_CONFIRM, any_addr());
        repeat ($urandom_range(0, 2))
            send_req(CMD_PACKET, any_addr());
        send_ticks($urandom_range(0, span(cur_reach) + 1));
        send_req(CMD_PACKET, any_addr());
        send_ticks($urandom_range(0, span(cur_pdelay) + 2 * span(cur_retx)));
        case ($urandom_range(0, 5))
            0, 1, 2: send_req(CMD_CONFIRM, any_addr());
            3:       send_req(CMD_REMOVE, any_addr());
            default: ;
        endcase
    endtask

    // Mostly lifecycles, the rest short bursts of unrelated requests.
    task automatic run_random(input int count);
        int stop_at;
        stop_at = n_sent + count;
        while (n_sent < stop_at) begin
            if ($urandom_range(0, 3) != 0) begin
                lifecycle();
            end else begin
                repeat ($urandom_range(1, 6))
                    send_req(any_cmd(), any_addr());
            end
        end
    endtask

    // Confirm, age exactly to stale, then send: leaves the entry in delay with
    // the timer armed from the current probe delay. The next settings change
    // then decides how that pending expiry resolves.
    task automatic park_in_delay(input int reach);
        send_req(CMD_CONFIRM, any_addr());
        send_ticks(reach);
        send_req(CMD_PACKET, any_addr());
    endtask

    // Result side: ready stalls drawn per response, with calm stretches.
    initial begin : sink
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_out_valid && i_out_ready))
                @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_REACHABLE;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_command      = CMD_TICK;
        i_link_address = '0;
        cur_reach      = REACHABLE_RST;
        cur_retx       = RETRANSMIT_RST;
        cur_pdelay     = PROBE_DELAY_RST;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset settings: remove and tick on an
        // empty entry, resolve with held packets, flush on confirmation,
        // address corners, remove dropping held packets without a flush.
        send_req(CMD_REMOVE, '1);
        send_req(CMD_TICK, '1);
        send_req(CMD_PACKET, '0);
        send_req(CMD_PACKET, 48'hAAAA_AAAA_AAAA);
        send_req(CMD_PACKET, '1);
        send_req(CMD_CONFIRM, '1);
        send_req(CMD_PACKET, '0);
        send_req(CMD_CONFIRM, '0);
        send_req(CMD_CONFIRM, 48'hAAAA_AAAA_AAAA);
        send_req(CMD_CONFIRM, 48'h5555_5555_5555);
        send_req(CMD_TICK, '0);
        send_req(CMD_REMOVE, '0);
        send_req(CMD_CONFIRM, any_addr());
        send_req(CMD_REMOVE, any_addr());
        send_req(CMD_PACKET, any_addr());
        send_req(CMD_REMOVE, any_addr());
        send_req(CMD_PACKET, any_addr());
        send_req(CMD_CONFIRM, any_addr());

        // Short timers: every state is reached within a few ticks.
        load_settings(32'd4, 32'd2, 32'd3, 8'd2, 32'd2);
        run_random(110);
        park_in_delay(4);

        // Longer probe delay with a still-fresh confirmation: the pending
        // delay expiry falls back to reachable.
        load_settings(32'd20, 32'd3, 32'd20, 8'd4, 32'd5);
        run_random(110);
        park_in_delay(20);

        // Minimum reachable time and retry limit, half-range intervals that never
        // fall due, a resolve time due at once; the pending delay expiry changes nothing.
        load_settings(32'd1, 32'h8000_0000, 32'h8000_0000, 8'd0, 32'hFFFF_FFFF);
        run_random(110);

        // Full-range reachable time, one-tick timers, retries never run out.
        load_settings(32'hFFFF_FFFF, 32'd1, 32'd1, 8'hFF, 32'd1);
        run_random(110);

        // Full-range retransmit and probe delay, plus a hold-queue overflow:
        // packets past the hold limit are dropped, then one confirm flushes.
        load_settings(32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd1, 32'd3);
        send_req(CMD_REMOVE, any_addr());
        repeat (HOLD_LIMIT_DEF + 3)
            send_req(CMD_PACKET, any_addr());
        send_req(CMD_CONFIRM, any_addr());
        run_random(110);

        // Drain, then leave room for any stray response to show up.
        quiesce();
        repeat (20) @(negedge i_clk);

        $display("%0d requests (%0d ticks, %0d packets, %0d confirms, %0d removes), %0d responses",
                 n_sent, n_ticks, n_packets, n_confirms, n_removes, n_responses);
        $display("%0d timer setting sets from one-tick to full-range, with a hold overflow",
                 n_settings);
        if (n_mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: neighbour_reachability_fsm.f
sv/nrf_pkg.sv
sv/nrf_front.sv
sv/nrf_queue.sv
sv/nrf_back.sv
sv/neighbour_reachability_fsm.sv
tb/nrf_result_checker.sv
tb/neighbour_reachability_fsm_test.sv
